@@ design/v3a_pkg.sv @@
// Package for the vector arithmetic unit: payload types, operation codes,
// the stage types shared by the root and quotient cells, and the rounding
// and saturation helpers. It depends on nothing else.
`default_nettype none

package v3a_pkg;

    // Operation codes carried in req_type.
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_SADD  = 4'd4;
    localparam logic [3:0] OP_SSUB  = 4'd5;
    localparam logic [3:0] OP_SMUL  = 4'd6;
    localparam logic [3:0] OP_SDIV  = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;
    localparam logic [3:0] OP_DIST  = 4'd9;
    localparam logic [3:0] OP_DOT   = 4'd10;
    localparam logic [3:0] OP_CROSS = 4'd11;
    localparam logic [3:0] OP_UNIT  = 4'd12;

    // One root cell per result bit, one quotient cell per quotient bit.
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // Input item.
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar_in;
    } v3a_req_t;

    // Result item.
    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar_out;
        logic               div_error;
    } v3a_res_t;

    // Operands and early results that ride alongside the root cells.
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
        logic [2:0][31:0] res_r;
        logic [31:0]      res_s;
    } sq_side_t;

    // One root cell's worth of state: radicand still to consume, partial
    // remainder and partial root.
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] f;
        sq_side_t    side;
    } sq_stage_t;

    // Per-lane state of the restoring divider.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] num;
        logic [33:0] d2;
        logic [31:0] q;
        logic        ovf;
    } div_lane_t;

    // What the output stage needs besides the quotients.
    typedef struct packed {
        logic             use_div;
        logic [2:0]       neg;
        logic             err;
        logic [2:0][31:0] res_r;
        logic [31:0]      res_s;
    } div_side_t;

    typedef struct packed {
        div_lane_t [2:0] lane;
        div_side_t       side;
    } div_stage_t;

    // Saturate a signed value to the Q16.16 range.
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return Q_MAX;
        end else if (v < -64'sd2147483648) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Shift right by 16, rounding half away from zero.
    function automatic logic [49:0] round_q(input logic signed [64:0] v);
        logic [64:0] mag;
        logic [64:0] sum;
        logic [49:0] r;
        mag = v[64] ? 65'(-v) : 65'(v);
        sum = mag + 65'd32768;
        r = {1'b0, sum[64:16]};
        return v[64] ? 50'(-r) : r;
    endfunction

    // Clamp an unsigned length to the positive Q16.16 range.
    function automatic logic [31:0] sat_u33(input logic [32:0] l);
        return (l > {1'b0, Q_MAX}) ? Q_MAX : l[31:0];
    endfunction

endpackage

`default_nettype wire

@@ design/v3a_sqrt_cell.sv @@
// One cell of the square root chain: takes two radicand bits and yields one
// bit of the root. Depends on v3a_pkg for the stage type.
`default_nettype none

module v3a_sqrt_cell (
    input  wire logic               aclk,
    input  wire logic               ce,
    input  wire v3a_pkg::sq_stage_t src_i,
    output v3a_pkg::sq_stage_t      dst_o
);
    import v3a_pkg::*;

    sq_stage_t stage_reg;
    sq_stage_t stage_next;

    // Bring in the next bit pair and try the trial subtrahend 4f+1.
    always_comb begin
        logic [35:0] sh;
        logic [35:0] trial;
        logic [35:0] diff;
        sh = {src_i.rem, src_i.rad[63:62]};
        trial = {2'b00, src_i.f, 2'b01};
        diff = sh - trial;
        stage_next = src_i;
        stage_next.rad = {src_i.rad[61:0], 2'b00};
        if (sh >= trial) begin
            stage_next.rem = diff[33:0];
            stage_next.f = {src_i.f[30:0], 1'b1};
        end else begin
            stage_next.rem = sh[33:0];
            stage_next.f = {src_i.f[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            stage_reg <= stage_next;
        end
    end

    assign dst_o = stage_reg;

endmodule

`default_nettype wire

@@ design/v3a_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit for each of the
// three lanes. Depends on v3a_pkg for the stage type.
`default_nettype none

module v3a_div_cell (
    input  wire logic                aclk,
    input  wire logic                ce,
    input  wire v3a_pkg::div_stage_t src_i,
    output v3a_pkg::div_stage_t      dst_o
);
    import v3a_pkg::*;

    div_stage_t stage_reg;
    div_stage_t stage_next;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        logic [2:0][34:0] sh;
        logic [2:0][34:0] diff;
        logic [2:0]       ge;
        stage_next = src_i;
        for (int i = 0; i < 3; i++) begin
            sh[i] = {src_i.lane[i].rem, src_i.lane[i].num[31]};
            diff[i] = sh[i] - {1'b0, src_i.lane[i].d2};
            ge[i] = (sh[i] >= {1'b0, src_i.lane[i].d2});
            stage_next.lane[i].rem = ge[i] ? diff[i][33:0] : sh[i][33:0];
            stage_next.lane[i].num = {src_i.lane[i].num[30:0], 1'b0};
            stage_next.lane[i].q = {src_i.lane[i].q[30:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            stage_reg <= stage_next;
        end
    end

    assign dst_o = stage_reg;

endmodule

`default_nettype wire

@@ design/vector3_arith_unit.sv @@
// Top level of the three-component Q16.16 vector arithmetic unit.
// Depends on v3a_pkg, v3a_sqrt_cell and v3a_div_cell.
//
//   Channel  Ports                       Carries
//   input    s_valid, s_ready, s_data    v3a_req_t: op code, vectors a, b, scalar
//   result   m_valid, m_ready, m_data    v3a_res_t: vector, scalar, error flag
//
// One item is taken every cycle while the output buffer has a free entry; each result
// is offered on m_valid once it has passed the 72 stage registers and been
// written into the output buffer.
// The stage registers are the 32-cell square root chain followed by the 32-cell
// quotient chain, with five operand and product stages ahead and three set-up
// stages between.
// Reset clears the stage valid bits and the two-entry output buffer.
// The whole chain holds while both output buffer entries are full.
`default_nettype none

module vector3_arith_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire v3a_pkg::v3a_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output v3a_pkg::v3a_res_t      m_data
);
    import v3a_pkg::*;

    localparam int NSTG = 5 + SQ_STEPS + 3 + DIV_STEPS;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
        logic [2:0][31:0] lin;
    } base_t;

    typedef struct packed {
        base_t            base;
        logic [5:0][31:0] mx;
        logic [5:0][31:0] my;
    } p1_t;

    typedef struct packed {
        base_t            base;
        logic [5:0][63:0] prod;
    } p2_t;

    typedef struct packed {
        base_t            base;
        logic [2:0][64:0] e;
        logic [63:0]      rad;
    } p3_t;

    typedef struct packed {
        base_t            base;
        logic [2:0][49:0] rnd;
        logic [63:0]      rad;
    } p4_t;

    typedef struct packed {
        sq_side_t    side;
        logic [32:0] len;
    } q_t;

    typedef struct packed {
        logic [2:0][48:0] num;
        logic [2:0][33:0] d2;
        div_side_t        side;
    } dp_t;

    logic            ce;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    p1_t        p1_reg, p1_next;
    p2_t        p2_reg, p2_next;
    p3_t        p3_reg, p3_next;
    p4_t        p4_reg, p4_next;
    sq_stage_t  p5_reg, p5_next;
    q_t         q_reg, q_next;
    dp_t        dp_reg, dp_next;
    div_stage_t d0_reg, d0_next;

    sq_stage_t  sq_pipe [0:SQ_STEPS];
    div_stage_t div_pipe [0:DIV_STEPS];

    v3a_res_t    fin;
    v3a_res_t    head_reg, head_next;
    v3a_res_t    tail_reg, tail_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        pop;

    // The chain advances whenever the output buffer has a free entry.
    assign ce = (cnt_reg != 2'd2);
    assign s_ready = ce;
    assign vld_next = {vld_reg[NSTG-2:0], s_valid};

    // Stage 1: saturated sums and differences, and multiplier operand choice.
    always_comb begin
        logic [2:0][31:0] av;
        logic [2:0][31:0] bv;
        logic [2:0][31:0] dsat;
        logic [32:0]      t;
        av = {s_data.a_z, s_data.a_y, s_data.a_x};
        bv = {s_data.b_z, s_data.b_y, s_data.b_x};
        p1_next.base.op = s_data.req_type;
        p1_next.base.a = av;
        p1_next.base.b = bv;
        p1_next.base.s = s_data.scalar_in;
        p1_next.mx = '0;
        p1_next.my = '0;
        for (int i = 0; i < 3; i++) begin
            t = {av[i][31], av[i]} - {bv[i][31], bv[i]};
            dsat[i] = sat32(64'($signed(t)));
            case (s_data.req_type)
                OP_ADD: begin
                    t = {av[i][31], av[i]} + {bv[i][31], bv[i]};
                    p1_next.base.lin[i] = sat32(64'($signed(t)));
                end
                OP_SUB: begin
                    p1_next.base.lin[i] = dsat[i];
                end
                OP_SADD: begin
                    t = {av[i][31], av[i]} + {s_data.scalar_in[31], s_data.scalar_in};
                    p1_next.base.lin[i] = sat32(64'($signed(t)));
                end
                OP_SSUB: begin
                    t = {av[i][31], av[i]} - {s_data.scalar_in[31], s_data.scalar_in};
                    p1_next.base.lin[i] = sat32(64'($signed(t)));
                end
                default: begin
                    p1_next.base.lin[i] = '0;
                end
            endcase
        end
        case (s_data.req_type)
            OP_MUL, OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    p1_next.mx[i] = av[i];
                    p1_next.my[i] = bv[i];
                end
            end
            OP_SMUL: begin
                for (int i = 0; i < 3; i++) begin
                    p1_next.mx[i] = av[i];
                    p1_next.my[i] = s_data.scalar_in;
                end
            end
            OP_NORM, OP_UNIT: begin
                for (int i = 0; i < 3; i++) begin
                    p1_next.mx[i] = av[i];
                    p1_next.my[i] = av[i];
                end
            end
            OP_DIST: begin
                for (int i = 0; i < 3; i++) begin
                    p1_next.mx[i] = dsat[i];
                    p1_next.my[i] = dsat[i];
                end
            end
            OP_CROSS: begin
                p1_next.mx[0] = av[1];
                p1_next.my[0] = bv[2];
                p1_next.mx[3] = av[2];
                p1_next.my[3] = bv[1];
                p1_next.mx[1] = av[2];
                p1_next.my[1] = bv[0];
                p1_next.mx[4] = av[0];
                p1_next.my[4] = bv[2];
                p1_next.mx[2] = av[0];
                p1_next.my[2] = bv[1];
                p1_next.mx[5] = av[1];
                p1_next.my[5] = bv[0];
            end
            default: begin
                p1_next.mx = '0;
                p1_next.my = '0;
            end
        endcase
    end

    // Stage 2: six signed products.
    always_comb begin
        p2_next.base = p1_reg.base;
        for (int k = 0; k < 6; k++) begin
            p2_next.prod[k] = 64'($signed(p1_reg.mx[k]) * $signed(p1_reg.my[k]));
        end
    end

    // Stage 3: cross differences and the sum of squares.
    always_comb begin
        p3_next.base = p2_reg.base;
        for (int i = 0; i < 3; i++) begin
            p3_next.e[i] = 65'($signed(p2_reg.prod[i])) - 65'($signed(p2_reg.prod[i+3]));
        end
        p3_next.rad = p2_reg.prod[0] + p2_reg.prod[1] + p2_reg.prod[2];
    end

    // Stage 4: round each term back to Q16.16.
    always_comb begin
        p4_next.base = p3_reg.base;
        p4_next.rad = p3_reg.rad;
        for (int i = 0; i < 3; i++) begin
            p4_next.rnd[i] = round_q($signed(p3_reg.e[i]));
        end
    end

    // Stage 5: final values of the direct operations; start the root chain.
    always_comb begin
        logic [51:0] dot;
        dot = 52'($signed(p4_reg.rnd[0])) + 52'($signed(p4_reg.rnd[1]))
            + 52'($signed(p4_reg.rnd[2]));
        p5_next.rad = p4_reg.rad;
        p5_next.rem = '0;
        p5_next.f = '0;
        p5_next.side.op = p4_reg.base.op;
        p5_next.side.a = p4_reg.base.a;
        p5_next.side.b = p4_reg.base.b;
        p5_next.side.s = p4_reg.base.s;
        p5_next.side.res_s = (p4_reg.base.op == OP_DOT) ? sat32(64'($signed(dot))) : '0;
        for (int i = 0; i < 3; i++) begin
            case (p4_reg.base.op)
                OP_ADD, OP_SUB, OP_SADD, OP_SSUB: begin
                    p5_next.side.res_r[i] = p4_reg.base.lin[i];
                end
                OP_MUL, OP_SMUL, OP_CROSS: begin
                    p5_next.side.res_r[i] = sat32(64'($signed(p4_reg.rnd[i])));
                end
                default: begin
                    p5_next.side.res_r[i] = '0;
                end
            endcase
        end
    end

    // Square root chain.
    assign sq_pipe[0] = p5_reg;
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        v3a_sqrt_cell u_sqrt_cell (
            .aclk  (aclk),
            .ce    (ce),
            .src_i (sq_pipe[k]),
            .dst_o (sq_pipe[k+1])
        );
    end

    // Round the root to nearest.
    always_comb begin
        q_next.side = sq_pipe[SQ_STEPS].side;
        q_next.len = {1'b0, sq_pipe[SQ_STEPS].f}
            + 33'(sq_pipe[SQ_STEPS].rem > {2'b00, sq_pipe[SQ_STEPS].f});
    end

    // Divider set-up: pick dividend and divisor, flag a zero divisor, saturate the length.
    always_comb begin
        logic [31:0] nm;
        logic [31:0] dsig;
        logic [32:0] dm;
        logic        is_div;
        logic        zero;
        logic [3:0]  op;
        op = q_reg.side.op;
        is_div = (op == OP_DIV) || (op == OP_SDIV) || (op == OP_UNIT);
        case (op)
            OP_DIV: begin
                zero = (q_reg.side.b[0] == '0) || (q_reg.side.b[1] == '0)
                    || (q_reg.side.b[2] == '0);
            end
            OP_SDIV: begin
                zero = (q_reg.side.s == '0);
            end
            OP_UNIT: begin
                zero = (q_reg.len == '0);
            end
            default: begin
                zero = 1'b0;
            end
        endcase
        dp_next.side.use_div = is_div && !zero;
        dp_next.side.err = ((op == OP_DIV) || (op == OP_SDIV)) && zero;
        dp_next.side.res_r = q_reg.side.res_r;
        if ((op == OP_NORM) || (op == OP_DIST)) begin
            dp_next.side.res_s = sat_u33(q_reg.len);
        end else begin
            dp_next.side.res_s = q_reg.side.res_s;
        end
        for (int i = 0; i < 3; i++) begin
            nm = q_reg.side.a[i][31] ? 32'(-q_reg.side.a[i]) : q_reg.side.a[i];
            dsig = (op == OP_DIV) ? q_reg.side.b[i] : q_reg.side.s;
            if (op == OP_UNIT) begin
                dm = q_reg.len;
                dp_next.side.neg[i] = q_reg.side.a[i][31];
            end else begin
                dm = dsig[31] ? {1'b0, 32'(-dsig)} : {1'b0, dsig};
                dp_next.side.neg[i] = q_reg.side.a[i][31] ^ dsig[31];
            end
            dp_next.num[i] = {nm, 17'd0} + {16'd0, dm};
            dp_next.d2[i] = {dm, 1'b0};
        end
    end

    // Quotient range check; load the divider lanes.
    always_comb begin
        d0_next.side = dp_reg.side;
        for (int i = 0; i < 3; i++) begin
            d0_next.lane[i].rem = {17'd0, dp_reg.num[i][48:32]};
            d0_next.lane[i].ovf = ({17'd0, dp_reg.num[i][48:32]} >= dp_reg.d2[i]);
            d0_next.lane[i].num = dp_reg.num[i][31:0];
            d0_next.lane[i].d2 = dp_reg.d2[i];
            d0_next.lane[i].q = '0;
        end
    end

    // Quotient chain.
    assign div_pipe[0] = d0_reg;
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        v3a_div_cell u_div_cell (
            .aclk  (aclk),
            .ce    (ce),
            .src_i (div_pipe[k]),
            .dst_o (div_pipe[k+1])
        );
    end

    // Apply signs, saturate and assemble the result item.
    always_comb begin
        logic [2:0][31:0] r;
        logic [31:0]      qm;
        logic             ovf;
        for (int i = 0; i < 3; i++) begin
            qm = div_pipe[DIV_STEPS].lane[i].q;
            ovf = div_pipe[DIV_STEPS].lane[i].ovf;
            if (!div_pipe[DIV_STEPS].side.use_div) begin
                r[i] = div_pipe[DIV_STEPS].side.res_r[i];
            end else if (div_pipe[DIV_STEPS].side.neg[i]) begin
                r[i] = (ovf || (qm[31] && (qm[30:0] != '0))) ? Q_MIN : 32'(-qm);
            end else begin
                r[i] = (ovf || qm[31]) ? Q_MAX : qm;
            end
        end
        fin.r_x = r[0];
        fin.r_y = r[1];
        fin.r_z = r[2];
        fin.scalar_out = div_pipe[DIV_STEPS].side.res_s;
        fin.div_error = div_pipe[DIV_STEPS].side.err;
    end

    // Two-entry output buffer.
    assign push = ce && vld_reg[NSTG-1];
    assign pop = m_valid && m_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                head_next = fin;
            end else begin
                tail_next = fin;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            head_next = tail_reg;
            cnt_next = cnt_reg - 2'd1;
        end else if (pop && push) begin
            if (cnt_reg == 2'd1) begin
                head_next = fin;
            end else begin
                head_next = tail_reg;
                tail_next = fin;
            end
        end
    end

    // Control state and stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cnt_reg <= 2'd0;
        end else begin
            if (ce) begin
                vld_reg <= vld_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (ce) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            q_reg <= q_next;
            dp_reg <= dp_next;
            d0_reg <= d0_next;
        end
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data = head_reg;

endmodule

`default_nettype wire

@@ test/tb_vector3_arith_unit.sv @@
// Self-checking testbench for vector3_arith_unit: directed rows, then random
// Q16.16 operand streams with random idling on both channels.
// Depends on v3a_pkg and the vector3_arith_unit RTL.
`timescale 1ns / 1ps

module tb_vector3_arith_unit;
    import v3a_pkg::*;

    typedef logic signed [71:0] wide_t;

    typedef struct {
        v3a_req_t req;
        bit       typed;
        v3a_res_t res;
    } row_t;

    localparam int    N_RANDOM  = 2000;
    localparam int    CALM_FROM = 1800;
    localparam int    LIMIT     = 400000;
    localparam wide_t WMAX      = 2147483647;
    localparam wide_t WMIN      = -WMAX - 1;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    v3a_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    v3a_res_t m_data;

    // Expectation plan pushed by the sender, resolved when the item is taken.
    row_t     plan_q[$];
    v3a_res_t awaited_q[$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       cycles = 0;
    bit       calm = 0;
    bit       hold_done = 0;

    vector3_arith_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Saturate a wide signed value to Q16.16.
    function automatic logic [31:0] clamp_q(input wide_t v);
        if (v > WMAX) begin
            return 32'h7FFF_FFFF;
        end
        if (v < WMIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Drop sixteen fraction bits, ties away from zero.
    function automatic wide_t drop_frac(input wide_t v);
        logic [71:0] m;
        wide_t       r;
        m = (v < 0) ? -v : v;
        m = (m + 72'd32768) >> 16;
        r = $signed(m);
        return (v < 0) ? -r : r;
    endfunction

    // Rounded Q16.16 quotient of n by d, d not zero.
    function automatic wide_t quotient_q(input wide_t n, input wide_t d);
        logic [71:0] nm;
        logic [71:0] dm;
        logic [71:0] q;
        wide_t       r;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = ((nm << 17) + dm) / (dm << 1);
        r = $signed(q);
        return ((n < 0) != (d < 0)) ? -r : r;
    endfunction

    // Square root rounded to nearest.
    function automatic wide_t root_near(input logic [71:0] sq);
        logic [71:0] f;
        logic [71:0] t;
        f = '0;
        for (int k = 33; k >= 0; k--) begin
            t = f | (72'd1 << k);
            if (t * t <= sq) begin
                f = t;
            end
        end
        if (sq - f * f > f) begin
            f = f + 1;
        end
        return $signed(f);
    endfunction

    function automatic wide_t length_of(input wide_t x, input wide_t y, input wide_t z);
        return root_near(x * x + y * y + z * z);
    endfunction

    // Expected result for one request.
    function automatic v3a_res_t vector_result(input v3a_req_t q);
        wide_t       a[3];
        wide_t       b[3];
        wide_t       s;
        wide_t       d[3];
        wide_t       acc;
        wide_t       len;
        logic [31:0] r[3];
        v3a_res_t    o;
        a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
        b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
        s = q.scalar_in;
        r[0] = '0; r[1] = '0; r[2] = '0;
        o = '0;
        case (q.req_type)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + b[i]);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - b[i]);
            OP_MUL: for (int i = 0; i < 3; i++) r[i] = clamp_q(drop_frac(a[i] * b[i]));
            OP_DIV: begin
                if (b[0] == 0 || b[1] == 0 || b[2] == 0) begin
                    o.div_error = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = clamp_q(quotient_q(a[i], b[i]));
                end
            end
            OP_SADD: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + s);
            OP_SSUB: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - s);
            OP_SMUL: for (int i = 0; i < 3; i++) r[i] = clamp_q(drop_frac(a[i] * s));
            OP_SDIV: begin
                if (s == 0) begin
                    o.div_error = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = clamp_q(quotient_q(a[i], s));
                end
            end
            OP_NORM: o.scalar_out = clamp_q(length_of(a[0], a[1], a[2]));
            OP_DIST: begin
                for (int i = 0; i < 3; i++) d[i] = $signed(clamp_q(a[i] - b[i]));
                o.scalar_out = clamp_q(length_of(d[0], d[1], d[2]));
            end
            OP_DOT: begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc = acc + drop_frac(a[i] * b[i]);
                o.scalar_out = clamp_q(acc);
            end
            OP_CROSS: begin
                r[0] = clamp_q(drop_frac(a[1] * b[2] - a[2] * b[1]));
                r[1] = clamp_q(drop_frac(a[2] * b[0] - a[0] * b[2]));
                r[2] = clamp_q(drop_frac(a[0] * b[1] - a[1] * b[0]));
            end
            OP_UNIT: begin
                len = length_of(a[0], a[1], a[2]);
                if (len != 0) begin
                    for (int i = 0; i < 3; i++) r[i] = clamp_q(quotient_q(a[i], len));
                end
            end
            default: ;
        endcase
        o.r_x = r[0];
        o.r_y = r[1];
        o.r_z = r[2];
        return o;
    endfunction

    function automatic v3a_req_t pack_req(input logic [3:0] op,
                                          input logic [31:0] ax, ay, az, bx, by, bz, sc);
        v3a_req_t q;
        q.req_type = op;
        q.a_x = ax; q.a_y = ay; q.a_z = az;
        q.b_x = bx; q.b_y = by; q.b_z = bz;
        q.scalar_in = sc;
        return q;
    endfunction

    function automatic v3a_res_t pack_res(input logic [31:0] rx, ry, rz, so,
                                          input logic err);
        v3a_res_t o;
        o.r_x = rx; o.r_y = ry; o.r_z = rz;
        o.scalar_out = so;
        o.div_error = err;
        return o;
    endfunction

    // Operand value: a mix of full-range, small, extreme and scaled numbers.
    function automatic logic [31:0] operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    3: v = ONE;
                    4: v = -ONE;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(1, 24);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // Take each accepted item and each accepted result on the clock edge.
    always @(posedge aclk) begin
        row_t     p;
        v3a_res_t want;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) begin
            p = plan_q.pop_front();
            awaited_q.push_back(p.typed ? p.res : vector_result(p.req));
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result %h", m_data);
                end
            end else begin
                want = awaited_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected r=(%h %h %h) s=%h e=%b, got r=(%h %h %h) s=%h e=%b",
                                 want.r_x, want.r_y, want.r_z, want.scalar_out, want.div_error,
                                 m_data.r_x, m_data.r_y, m_data.r_z, m_data.scalar_out,
                                 m_data.div_error);
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off, steady at the end.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!hold_done && items_sent >= 400) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= $urandom_range(0, 2) != 0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input row_t r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        plan_q.push_back(r);
        s_valid <= 1'b1;
        s_data  <= r.req;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    initial begin
        row_t rows[$];
        row_t r;
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; typed results where they are obvious.
        rows.push_back('{pack_req(OP_ADD, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0), 1,
                         pack_res(3*ONE, 3*ONE, 3*ONE, 0, 0)});
        rows.push_back('{pack_req(OP_ADD, mx, mx, mx, mx, mx, mx, mx), 1,
                         pack_res(mx, mx, mx, 0, 0)});
        rows.push_back('{pack_req(OP_SUB, mn, mn, mn, mx, mx, mx, 0), 1,
                         pack_res(mn, mn, mn, 0, 0)});
        rows.push_back('{pack_req(OP_MUL, 2*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 3*ONE, 0), 1,
                         pack_res(6*ONE, 6*ONE, 6*ONE, 0, 0)});
        rows.push_back('{pack_req(OP_MUL, mn, mx, mn, mn, mx, mx, 0), 0, '0});
        rows.push_back('{pack_req(OP_DIV, ONE, mx, mn, 3*ONE, -7, 1, 0), 0, '0});
        rows.push_back('{pack_req(OP_DIV, ONE, ONE, ONE, ONE, 0, ONE, 0), 1,
                         pack_res(0, 0, 0, 0, 1)});
        rows.push_back('{pack_req(OP_SADD, ONE, mx, mn, 0, 0, 0, mx), 0, '0});
        rows.push_back('{pack_req(OP_SSUB, ONE, mx, mn, 0, 0, 0, mn), 0, '0});
        rows.push_back('{pack_req(OP_SMUL, ONE, mx, mn, 0, 0, 0, -3*ONE), 0, '0});
        rows.push_back('{pack_req(OP_SDIV, ONE, mx, mn, 0, 0, 0, 5), 0, '0});
        rows.push_back('{pack_req(OP_SDIV, ONE, ONE, ONE, 0, 0, 0, 0), 1,
                         pack_res(0, 0, 0, 0, 1)});
        rows.push_back('{pack_req(OP_NORM, 3*ONE, 4*ONE, 0, mx, mx, mx, mx), 1,
                         pack_res(0, 0, 0, 5*ONE, 0)});
        rows.push_back('{pack_req(OP_NORM, mn, mn, mn, 0, 0, 0, 0), 1,
                         pack_res(0, 0, 0, mx, 0)});
        rows.push_back('{pack_req(OP_DIST, mx, 12345, mn, mn, -ONE, mx, 0), 0, '0});
        rows.push_back('{pack_req(OP_DOT, mx, mn, mx, mx, mx, mn, 0), 0, '0});
        rows.push_back('{pack_req(OP_CROSS, mx, mn, 3, mn, mx, -ONE, 0), 0, '0});
        rows.push_back('{pack_req(OP_UNIT, 0, 0, 0, ONE, ONE, ONE, ONE), 1,
                         pack_res(0, 0, 0, 0, 0)});
        rows.push_back('{pack_req(OP_UNIT, 3*ONE, -4*ONE, 1, 0, 0, 0, 0), 0, '0});
        rows.push_back('{pack_req(OP_UNIT, 0, 0, 1, 0, 0, 0, 0), 0, '0});
        rows.push_back('{pack_req(4'd13, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1, '0});
        rows.push_back('{pack_req(4'd14, mx, mx, mx, mx, mx, mx, mx), 1, '0});
        rows.push_back('{pack_req(4'd15, mn, mn, mn, mn, mn, mn, mn), 1, '0});
        foreach (rows[i]) begin
            send_item(rows[i]);
        end

        // Random operand streams, mostly defined operation codes.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= CALM_FROM) begin
                calm = 1;
            end
            r.req = pack_req(($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                           : 4'($urandom_range(0, 12)),
                             operand(), operand(), operand(),
                             operand(), operand(), operand(), operand());
            r.typed = 0;
            r.res = '0;
            send_item(r);
        end
        s_valid <= 1'b0;

        while (awaited_q.size() != 0 || plan_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
